>>> src/hbsc_pkg.sv
// ----------------------------------------------------------------------------
// hbsc_pkg
// Shared types, constants and lookup functions of the six-step hall commutator.
// ----------------------------------------------------------------------------
`default_nettype none

package hbsc_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int DUTY_W       = 8;
  localparam int RPM_W        = 24;
  localparam int MAGNET_PAIRS = 2;
  localparam int COUNT_BITS   = 20;
  localparam int PROD_W       = (COUNT_BITS + 4 > RPM_W) ? COUNT_BITS + 4 : RPM_W;

  localparam logic [DUTY_W-1:0]     DUTY_RESET      = DUTY_W'(150);
  localparam logic [SAMPLE_W-1:0]   THRESHOLD_RESET = SAMPLE_W'(2048);
  localparam logic [RPM_W-1:0]      TOLERANCE_RESET = RPM_W'(20);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX       = {COUNT_BITS{1'b1}};
  localparam logic [RPM_W-1:0]      RPM_MAX         = {RPM_W{1'b1}};

  // Item commands.
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_STOP   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_DUTY      = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_TOLERANCE = 2'd2;

  // Hall codes; 1 to 6 carry a drive pattern, 0 and 7 carry none.
  localparam logic [2:0] HALL_1 = 3'd1;
  localparam logic [2:0] HALL_2 = 3'd2;
  localparam logic [2:0] HALL_3 = 3'd3;
  localparam logic [2:0] HALL_4 = 3'd4;
  localparam logic [2:0] HALL_5 = 3'd5;
  localparam logic [2:0] HALL_6 = 3'd6;
  localparam logic [2:0] HALL_NONE = 3'd0;
  localparam logic [2:0] HALL_ALL  = 3'd7;

  localparam logic [2:0] SEQ_LAST = 3'd5;

  typedef struct packed {
    logic [1:0]          command;
    logic [SAMPLE_W-1:0] sample_u;
    logic [SAMPLE_W-1:0] sample_v;
    logic [SAMPLE_W-1:0] sample_w;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_u;
    logic [DUTY_W-1:0] duty_v;
    logic [DUTY_W-1:0] duty_w;
    logic              low_u;
    logic              low_v;
    logic              low_w;
    logic              invalid_hall;
    logic              rpm_reported;
    logic [RPM_W-1:0]  rpm_value;
  } out_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [SAMPLE_W-1:0] trip_level;
    logic [RPM_W-1:0]    report_band;
  } cfg_t;

  // Hall code of sequence position 0..5 (order 1,5,4,6,2,3).
  function automatic logic [2:0] seq_code(input logic [2:0] idx);
    logic [2:0] c;
    case (idx)
      3'd0:    c = HALL_1;
      3'd1:    c = HALL_5;
      3'd2:    c = HALL_4;
      3'd3:    c = HALL_6;
      3'd4:    c = HALL_2;
      3'd5:    c = HALL_3;
      default: c = HALL_NONE;
    endcase
    return c;
  endfunction

  // Sequence position of a hall code; found is 0 for codes outside the sequence.
  function automatic logic [3:0] seq_pos(input logic [2:0] code);
    logic [3:0] r;
    case (code)
      HALL_1:  r = {1'b1, 3'd0};
      HALL_5:  r = {1'b1, 3'd1};
      HALL_4:  r = {1'b1, 3'd2};
      HALL_6:  r = {1'b1, 3'd3};
      HALL_2:  r = {1'b1, 3'd4};
      HALL_3:  r = {1'b1, 3'd5};
      default: r = {1'b0, 3'd0};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/hall_bldc_six_step_commutator.sv
// ----------------------------------------------------------------------------
// hall_bldc_six_step_commutator
// Six-step BLDC commutation from three analog hall samples, with rpm reports.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload                    Direction
//   in_       in_valid / in_stall   in_item  (hbsc_pkg)        into block
//   out_      out_valid / out_stall out_item (hbsc_pkg)        out of block
//   cfg_      cfg_valid / cfg_ready cfg_index, cfg_wdata       into block
//
// Every item produces exactly one result item. An accepted item sits in the
// input register, and when it moves on the step logic writes its result into
// the output register, from which the result is presented. One item can be
// accepted every cycle while the result side does not stall. Reset is
// synchronous and active low; it clears the commutation state, the valid
// flags and loads the register defaults. A stall on the result side holds
// the output register and then backs up into the input register; in_stall
// rises only when both stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_bldc_six_step_commutator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire hbsc_pkg::in_item_t         in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output hbsc_pkg::out_item_t             out_item,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [hbsc_pkg::RPM_W-1:0] cfg_wdata
);
  import hbsc_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  cfg_t      cfg;
  logic      in_take;
  logic      advance;

  // Registers accept writes at any time; the user writes them only when idle.
  assign cfg_ready = 1'b1;

  hbsc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // The item in the input register moves on when the output register is free
  // or is being emptied in this cycle. The state update happens on that move.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  hbsc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> src/hbsc_cfg.sv
// ----------------------------------------------------------------------------
// hbsc_cfg
// Configuration register file: duty, hall threshold and rpm tolerance.
// ----------------------------------------------------------------------------
`default_nettype none

module hbsc_cfg (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire logic [1:0]              wr_index,
  input  wire logic [hbsc_pkg::RPM_W-1:0] wr_data,
  output hbsc_pkg::cfg_t               cfg
);
  import hbsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_DUTY:      cfg_nxt.duty        = wr_data[DUTY_W-1:0];
        REG_THRESHOLD: cfg_nxt.trip_level  = wr_data[SAMPLE_W-1:0];
        REG_TOLERANCE: cfg_nxt.report_band = wr_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty        <= DUTY_RESET;
      cfg_r.trip_level  <= THRESHOLD_RESET;
      cfg_r.report_band <= TOLERANCE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> src/hbsc_core.sv
// ----------------------------------------------------------------------------
// hbsc_core
// Commutation state and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module hbsc_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire hbsc_pkg::in_item_t item,
  input  wire hbsc_pkg::cfg_t     cfg,
  output hbsc_pkg::out_item_t     result
);
  import hbsc_pkg::*;

  logic [2:0]            last_hall_r, last_hall_nxt;
  logic [2:0]            drive_r, drive_nxt;
  logic [2:0]            seq_idx_r, seq_idx_nxt;
  logic                  stopped_r, stopped_nxt;
  logic                  adv_r, adv_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [RPM_W-1:0]      last_rpm_r, last_rpm_nxt;

  logic [2:0]            code;
  logic [3:0]            pos;
  logic [2:0]            base_idx;
  logic [2:0]            adv_idx;
  logic [COUNT_BITS-1:0] count_inc;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     rpm_full;
  logic [RPM_W-1:0]      rpm_sat;
  logic [RPM_W-1:0]      diff;
  logic                  active;
  logic                  invalid;
  logic                  reported;

  always_comb begin
    code = {item.sample_u > cfg.trip_level,
            item.sample_v > cfg.trip_level,
            item.sample_w > cfg.trip_level};
    pos      = seq_pos(code);
    base_idx = pos[3] ? pos[2:0] : seq_idx_r;
    adv_idx  = (base_idx == SEQ_LAST) ? 3'd0 : base_idx + 3'd1;
    count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

    // count * 10 as two shifted copies, then divided by the pole pairs.
    prod     = (PROD_W'(count_r) << 3) + (PROD_W'(count_r) << 1);
    rpm_full = prod / PROD_W'(MAGNET_PAIRS);
    rpm_sat  = (rpm_full > PROD_W'(RPM_MAX)) ? RPM_MAX : rpm_full[RPM_W-1:0];
    diff     = (rpm_sat >= last_rpm_r) ? rpm_sat - last_rpm_r : last_rpm_r - rpm_sat;

    active = !stopped_r && (cfg.duty != '0);

    last_hall_nxt = last_hall_r;
    drive_nxt     = drive_r;
    seq_idx_nxt   = seq_idx_r;
    stopped_nxt   = stopped_r;
    adv_nxt       = adv_r;
    count_nxt     = count_r;
    last_rpm_nxt  = last_rpm_r;
    invalid       = 1'b0;
    reported      = 1'b0;

    case (item.command)
      CMD_SAMPLE: begin
        if (active) begin
          invalid = (code == HALL_NONE) || (code == HALL_ALL);
          if (adv_r) begin
            seq_idx_nxt   = adv_idx;
            drive_nxt     = seq_code(adv_idx);
            last_hall_nxt = seq_code(adv_idx);
            count_nxt     = count_inc;
            adv_nxt       = 1'b0;
          end else if (code != last_hall_r) begin
            drive_nxt     = code;
            last_hall_nxt = code;
            count_nxt     = count_inc;
          end
        end
      end
      CMD_TICK: begin
        count_nxt = '0;
        if (diff >= cfg.report_band) begin
          last_rpm_nxt = rpm_sat;
          reported     = 1'b1;
        end
      end
      CMD_START: begin
        stopped_nxt = 1'b0;
        adv_nxt     = 1'b1;
      end
      default: begin
        stopped_nxt = 1'b1;
        drive_nxt   = HALL_NONE;
      end
    endcase

    result = '0;
    case (drive_nxt)
      HALL_1:  begin result.duty_u = cfg.duty; result.low_v = 1'b1; end
      HALL_5:  begin result.duty_u = cfg.duty; result.low_w = 1'b1; end
      HALL_4:  begin result.duty_v = cfg.duty; result.low_w = 1'b1; end
      HALL_6:  begin result.duty_v = cfg.duty; result.low_u = 1'b1; end
      HALL_2:  begin result.duty_w = cfg.duty; result.low_u = 1'b1; end
      HALL_3:  begin result.duty_w = cfg.duty; result.low_v = 1'b1; end
      default: result = '0;
    endcase
    result.invalid_hall = invalid;
    result.rpm_reported = reported;
    result.rpm_value    = last_rpm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_hall_r <= HALL_NONE;
      drive_r     <= HALL_NONE;
      seq_idx_r   <= 3'd0;
      stopped_r   <= 1'b0;
      adv_r       <= 1'b0;
      count_r     <= '0;
      last_rpm_r  <= '0;
    end else if (fire) begin
      last_hall_r <= last_hall_nxt;
      drive_r     <= drive_nxt;
      seq_idx_r   <= seq_idx_nxt;
      stopped_r   <= stopped_nxt;
      adv_r       <= adv_nxt;
      count_r     <= count_nxt;
      last_rpm_r  <= last_rpm_nxt;
    end
  end

endmodule

`default_nettype wire
